>>> hw/rtl/splt_pkg.sv
// Package for the sorted partition lock table.
// Holds the command, status and state codes and the item structs.
// No dependencies.
package splt_pkg;

    localparam int KEY_W     = 64;
    localparam int IDX_W     = 8;
    localparam int OUT_CNT_W = 16;
    localparam int TOT_W     = 9;

    typedef enum logic [2:0] {
        CMD_INSERT       = 3'd0,
        CMD_REMOVE       = 3'd1,
        CMD_READ_LOCK    = 3'd2,
        CMD_READ_UNLOCK  = 3'd3,
        CMD_WRITE_LOCK   = 3'd4,
        CMD_WRITE_UNLOCK = 3'd5,
        CMD_FIND_INDEX   = 3'd6,
        CMD_READ_COUNTER = 3'd7
    } command_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_BUSY      = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_CHECK,
        FSM_SHIFT_UP,
        FSM_WRITE_NEW,
        FSM_SHIFT_DOWN
    } state_t;

    typedef struct packed {
        command_t                 command;
        logic signed [KEY_W-1:0]  key_time;
        logic signed [KEY_W-1:0]  key_txn;
    } in_t;

    typedef struct packed {
        status_t                     status;
        logic [IDX_W-1:0]            entry_index;
        logic signed [OUT_CNT_W-1:0] counter_value;
        logic [TOT_W-1:0]            entry_total;
    } out_t;

    typedef struct packed {
        logic less;
        logic equal;
    } cmp_t;

endpackage

>>> hw/rtl/sorted_partition_lock_table.sv
// Sorted partition lock table: one command per item, one result per item.
// Lookup is a binary search, one memory read per binary search step.
// Insert moves every later entry one place up, then writes the new entry.
// Remove moves every later entry one place down; items are taken one at a time.
// The result shows for one cycle with done; the receiver cannot stall it.
// Reset empties the table at once; entry contents are left undefined.
module sorted_partition_lock_table #(
    parameter int TABLE_DEPTH  = 256,
    parameter int COUNTER_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  splt_pkg::in_t  request,
    output logic           done,
    output splt_pkg::out_t result
);
    import splt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int CB = COUNTER_BITS;
    localparam int EW = 2 * KEY_W + CB;
    localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CNT_MIN = {1'b1, {(CB-1){1'b0}}};

    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rd_data;

    state_t        state_reg, state_next;
    in_t           req_reg, req_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] shift_reg, shift_next;
    logic [CW-1:0] count_reg, count_next;
    out_t          res_reg, res_next;
    logic          done_reg, done_next;

    logic          re, we;
    logic [AW-1:0] raddr, waddr;
    logic [EW-1:0] wdata;

    logic signed [KEY_W-1:0] rd_time, rd_txn;
    logic signed [CB-1:0]    rd_cnt, c_new;
    cmp_t                    cmp;
    logic [CW-1:0]           lo_s, hi_s;
    logic [CW:0]             mid_sum;
    logic                    found, refused;

    assign rd_time = rd_data[EW-1 -: KEY_W];
    assign rd_txn  = rd_data[EW-KEY_W-1 -: KEY_W];
    assign rd_cnt  = rd_data[CB-1:0];

    splt_cmp u_cmp (
        .entry_time (rd_time),
        .entry_txn  (rd_txn),
        .key_time   (req_reg.key_time),
        .key_txn    (req_reg.key_txn),
        .cmp        (cmp)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        shift_reg <= shift_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        re         = 1'b0;
        raddr      = mid_reg[AW-1:0];
        we         = 1'b0;
        waddr      = lo_reg[AW-1:0];
        wdata      = {req_reg.key_time, req_reg.key_txn, {CB{1'b0}}};
        lo_s       = lo_reg;
        hi_s       = hi_reg;
        mid_sum    = '0;
        found      = (lo_reg < count_reg) && cmp.equal;
        refused    = 1'b0;
        c_new      = rd_cnt;

        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    lo_next  = '0;
                    hi_next  = count_reg;
                    mid_next = count_reg >> 1;
                    raddr    = mid_next[AW-1:0];
                    re       = count_reg != '0;
                    state_next = (count_reg != '0) ? FSM_SEARCH : FSM_CHECK;
                end
            end

            FSM_SEARCH:
            begin
                // Narrow the range with the entry read last cycle and issue the next read.
                if (cmp.less)
                begin
                    lo_s = mid_reg + 1'b1;
                end
                else
                begin
                    hi_s = mid_reg;
                end
                lo_next = lo_s;
                hi_next = hi_s;
                mid_sum = ({1'b0, lo_s} + {1'b0, hi_s}) >> 1;
                if (lo_s < hi_s)
                begin
                    mid_next = mid_sum[CW-1:0];
                    raddr    = mid_sum[AW-1:0];
                    re       = 1'b1;
                end
                else
                begin
                    raddr      = lo_s[AW-1:0];
                    re         = lo_s < count_reg;
                    state_next = FSM_CHECK;
                end
            end

            FSM_CHECK:
            begin
                res_next.status        = ST_OK;
                res_next.entry_index   = '0;
                res_next.counter_value = '0;
                res_next.entry_total   = TOT_W'(count_reg);
                done_next  = 1'b1;
                state_next = FSM_IDLE;
                if (req_reg.command == CMD_INSERT)
                begin
                    if (found)
                    begin
                        res_next.status        = ST_PRESENT;
                        res_next.entry_index   = IDX_W'(lo_reg);
                        res_next.counter_value = OUT_CNT_W'(rd_cnt);
                    end
                    else if (count_reg >= CW'(TABLE_DEPTH))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else if (lo_reg == count_reg)
                    begin
                        we                   = 1'b1;
                        count_next           = count_reg + 1'b1;
                        res_next.entry_index = IDX_W'(lo_reg);
                        res_next.entry_total = TOT_W'(count_next);
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        re         = 1'b1;
                        raddr      = AW'(count_reg - 1'b1);
                        shift_next = count_reg - 1'b1;
                        state_next = FSM_SHIFT_UP;
                    end
                end
                else if (!found)
                begin
                    res_next.status = ST_NOT_FOUND;
                end
                else
                begin
                    res_next.entry_index = IDX_W'(lo_reg);
                    case (req_reg.command)
                        CMD_REMOVE:
                        begin
                            if (lo_reg == count_reg - 1'b1)
                            begin
                                count_next           = count_reg - 1'b1;
                                res_next.entry_total = TOT_W'(count_next);
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                re         = 1'b1;
                                raddr      = AW'(lo_reg + 1'b1);
                                shift_next = lo_reg + 1'b1;
                                state_next = FSM_SHIFT_DOWN;
                            end
                        end
                        CMD_READ_LOCK:
                        begin
                            refused = (rd_cnt < 0) || (rd_cnt == CNT_MAX);
                            c_new   = rd_cnt + CB'(1);
                        end
                        CMD_READ_UNLOCK:
                        begin
                            refused = rd_cnt <= 0;
                            c_new   = rd_cnt - CB'(1);
                        end
                        CMD_WRITE_LOCK:
                        begin
                            refused = (rd_cnt > 0) || (rd_cnt == CNT_MIN);
                            c_new   = rd_cnt - CB'(1);
                        end
                        CMD_WRITE_UNLOCK:
                        begin
                            c_new = '0;
                        end
                        default:
                        begin
                            c_new = rd_cnt;
                        end
                    endcase
                    if (refused)
                    begin
                        c_new           = rd_cnt;
                        res_next.status = ST_BUSY;
                    end
                    if (req_reg.command != CMD_REMOVE)
                    begin
                        res_next.counter_value = OUT_CNT_W'(c_new);
                        we    = 1'b1;
                        wdata = {rd_time, rd_txn, c_new};
                    end
                end
            end

            FSM_SHIFT_UP:
            begin
                // Move the entry read last cycle one place up, walking down to the key.
                we    = 1'b1;
                waddr = AW'(shift_reg + 1'b1);
                wdata = rd_data;
                if (shift_reg == lo_reg)
                begin
                    state_next = FSM_WRITE_NEW;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = AW'(shift_reg - 1'b1);
                    shift_next = shift_reg - 1'b1;
                end
            end

            FSM_WRITE_NEW:
            begin
                we                     = 1'b1;
                count_next             = count_reg + 1'b1;
                res_next.status        = ST_OK;
                res_next.entry_index   = IDX_W'(lo_reg);
                res_next.counter_value = '0;
                res_next.entry_total   = TOT_W'(count_next);
                done_next              = 1'b1;
                state_next             = FSM_IDLE;
            end

            FSM_SHIFT_DOWN:
            begin
                we    = 1'b1;
                waddr = AW'(shift_reg - 1'b1);
                wdata = rd_data;
                if (shift_reg == count_reg - 1'b1)
                begin
                    count_next             = count_reg - 1'b1;
                    res_next.status        = ST_OK;
                    res_next.entry_index   = IDX_W'(lo_reg);
                    res_next.counter_value = '0;
                    res_next.entry_total   = TOT_W'(count_next);
                    done_next              = 1'b1;
                    state_next             = FSM_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = AW'(shift_reg + 1'b1);
                    shift_next = shift_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign busy   = state_reg != FSM_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != FSM_IDLE)
        else $error("result strobe without a command in progress");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re && (waddr == raddr)))
        else $error("read and write of the same entry in one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("entry count changed without a result");

endmodule

>>> hw/rtl/splt_cmp.sv
// Key comparator for the sorted partition lock table.
// Orders by time, then by transaction number, both signed; uses splt_pkg.
module splt_cmp (
    input  logic signed [splt_pkg::KEY_W-1:0] entry_time,
    input  logic signed [splt_pkg::KEY_W-1:0] entry_txn,
    input  logic signed [splt_pkg::KEY_W-1:0] key_time,
    input  logic signed [splt_pkg::KEY_W-1:0] key_txn,
    output splt_pkg::cmp_t                    cmp
);
    import splt_pkg::*;

    always_comb
    begin
        if (entry_time != key_time)
        begin
            cmp.less = entry_time < key_time;
        end
        else
        begin
            cmp.less = entry_txn < key_txn;
        end
        cmp.equal = (entry_time == key_time) && (entry_txn == key_txn);
    end

endmodule
